/* rtl/fmfb_pkg.sv */
`timescale 1ns / 1ps

package fmfb_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int BANK_WORDS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_WORDS = 2 * BANK_WORDS;

    localparam int PIXEL_W     = 32;
    localparam int DIM_W       = 7;
    localparam int MODE_W      = 1;
    localparam int BLANK_W     = 6;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = $clog2(STORE_WORDS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_FLIP_MODE    = 2'd2,
        REG_BLANK_COLS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [PIXEL_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } store_req_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic             bank,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        return ADDR_W'(bank) * ADDR_W'(BANK_WORDS)
             + ADDR_W'(row) * ADDR_W'(MAX_WIDTH)
             + ADDR_W'(col);
    endfunction

endpackage

/* rtl/frame_mirror_flip_with_blanking_unit.sv */
`timescale 1ns / 1ps

// Mirror or flip of a raster-order RGBA pixel stream through a ping-pong frame store.
// Pixels enter on the s_axis channel, one beat per pixel. Each beat is written into
// the current bank; once a whole frame is stored, every beat also yields one pixel of
// the previous frame for the same raster position on m_axis, mirrored (flip_mode 0) or
// flipped (flip_mode 1), zero inside the blank_cols margin. m_axis_tlast marks the last
// pixel of an output frame. The first frame after reset or a geometry write gives no beats.
// Throughput: one beat per cycle unless m_axis stalls; one store write and read per beat.
// A result beat passes the store read register, loaded at the edge that accepts its input
// beat, then the output register, which presents it on m_axis.
// Reset clears counters, bank select, frame-valid flag and pipe valid flags, sets width and
// height to 64; store contents are not cleared and are never read before being written.
// When the receiver stalls, up to two results are held in the pipe, then s_axis_tready
// drops until m_axis_tready returns.
// Configuration is written through cfg_we/cfg_index/cfg_data while the stream is idle.

module frame_mirror_flip_with_blanking_unit
    import fmfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,   // [31:0] in_pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PIXEL_W-1:0]     m_axis_tdata,   // [31:0] out_pixel
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [MODE_W-1:0]  flip_mode_reg;
    logic [BLANK_W-1:0] blank_cols_reg;

    logic [COL_W-1:0]   column_count_reg;
    logic [ROW_W-1:0]   row_count_reg;
    logic               write_bank_reg;
    logic               previous_frame_valid_reg;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_blank_reg;
    logic               out_valid_reg;
    logic               out_last_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic [PIXEL_W-1:0] out_pixel_next;

    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   src_col;
    logic [ROW_W-1:0]   src_row;
    logic               col_end;
    logic               row_end;
    logic               at_last;
    logic               blank;
    logic               in_accept;
    logic               s1_move;
    logic               geom_write;
    logic [PIXEL_W-1:0] rd_data;
    store_req_t         req;

    always_comb
    begin
        if (frame_width_reg == '0)
            w = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            w = DIM_W'(MAX_WIDTH);
        else
            w = frame_width_reg;

        if (frame_height_reg == '0)
            h = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            h = DIM_W'(MAX_HEIGHT);
        else
            h = frame_height_reg;

        col = (DIM_W'(column_count_reg) >= w) ? COL_W'(w - DIM_W'(1)) : column_count_reg;
        row = (DIM_W'(row_count_reg) >= h) ? ROW_W'(h - DIM_W'(1)) : row_count_reg;

        col_end = (DIM_W'(col) + DIM_W'(1)) >= w;
        row_end = (DIM_W'(row) + DIM_W'(1)) >= h;
        at_last = col_end && row_end;

        if (flip_mode_reg != '0)
        begin
            src_col = col;
            src_row = ROW_W'(h - DIM_W'(1) - DIM_W'(row));
        end
        else
        begin
            src_col = COL_W'(w - DIM_W'(1) - DIM_W'(col));
            src_row = row;
        end

        blank = (blank_cols_reg != '0)
             && ((DIM_W'(col) < DIM_W'(blank_cols_reg))
              || ((DIM_W'(col) + DIM_W'(blank_cols_reg)) >= w));
    end

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign geom_write    = cfg_we && ((cfg_index == REG_FRAME_WIDTH)
                                   || (cfg_index == REG_FRAME_HEIGHT));

    always_comb
    begin
        req.wr_en   = in_accept;
        req.wr_addr = store_addr(write_bank_reg, row, col);
        req.wr_data = s_axis_tdata;
        req.rd_en   = in_accept && previous_frame_valid_reg;
        req.rd_addr = store_addr(!write_bank_reg, src_row, src_col);
    end

    fmfb_frame_store u_store
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg          <= DIM_W'(64);
            frame_height_reg         <= DIM_W'(64);
            flip_mode_reg            <= '0;
            blank_cols_reg           <= '0;
            column_count_reg         <= '0;
            row_count_reg            <= '0;
            write_bank_reg           <= 1'b0;
            previous_frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    REG_FLIP_MODE:    flip_mode_reg    <= cfg_data[MODE_W-1:0];
                    REG_BLANK_COLS:   blank_cols_reg   <= cfg_data[BLANK_W-1:0];
                    default:          ;
                endcase
            end

            if (geom_write)
            begin
                column_count_reg         <= '0;
                row_count_reg            <= '0;
                previous_frame_valid_reg <= 1'b0;
            end
            else if (in_accept)
            begin
                if (!col_end)
                begin
                    column_count_reg <= col + COL_W'(1);
                    row_count_reg    <= row;
                end
                else
                begin
                    column_count_reg <= '0;
                    if (!row_end)
                    begin
                        row_count_reg <= row + ROW_W'(1);
                    end
                    else
                    begin
                        row_count_reg            <= '0;
                        write_bank_reg           <= !write_bank_reg;
                        previous_frame_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Advance the result pipe: stage 1 follows the store read, then the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= previous_frame_valid_reg;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_pixel_next = s1_blank_reg ? '0 : rd_data;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_last_reg  <= at_last;
            s1_blank_reg <= blank;
        end
        if (s1_move)
        begin
            out_pixel_reg <= out_pixel_next;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while the result pipe has room");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (DIM_W'(column_count_reg) < w) && (DIM_W'(row_count_reg) < h))
        else $error("raster counter beyond frame geometry");

    a_frame_end_swaps_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && at_last && !geom_write)
        |=> (write_bank_reg != $past(write_bank_reg)) && previous_frame_valid_reg)
        else $error("bank not swapped at end of frame");

    a_held_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> $stable(rd_data))
        else $error("store read data changed under a held result");
`endif

endmodule

/* rtl/fmfb_frame_store.sv */
`timescale 1ns / 1ps

module fmfb_frame_store
    import fmfb_pkg::*;
(
    input  logic               clk,
    input  store_req_t         req,
    output logic [PIXEL_W-1:0] rd_data
);

    logic [PIXEL_W-1:0] mem [STORE_WORDS];
    logic [PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/frame_mirror_flip_checker.sv */
`timescale 1ns / 1ps

module frame_mirror_flip_checker
    import fmfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,   // [31:0] in_pixel
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [PIXEL_W-1:0]     m_axis_tdata,   // [31:0] out_pixel
    input  logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } mirror_beat_t;

    bit   [PIXEL_W-1:0] pixel_store [STORE_WORDS];
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               flip_reg;
    logic [BLANK_W-1:0] blank_reg;
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    bit                 wr_bank;
    bit                 prev_ok;
    mirror_beat_t       mirrored_q [$];

    function automatic void apply_reg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_reg = val[DIM_W-1:0];
                col_cnt   = 0;
                row_cnt   = 0;
                prev_ok   = 1'b0;
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = val[DIM_W-1:0];
                col_cnt    = 0;
                row_cnt    = 0;
                prev_ok    = 1'b0;
            end
            REG_FLIP_MODE:
            begin
                flip_reg = val[0];
            end
            REG_BLANK_COLS:
            begin
                blank_reg = val[BLANK_W-1:0];
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void mirror_pixel(input logic [PIXEL_W-1:0] pix);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        int unsigned        src_r;
        int unsigned        src_c;
        int unsigned        blank;
        logic [PIXEL_W-1:0] out_pix;
        logic               frame_end;
        w     = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h     = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        blank = blank_reg;
        c     = (col_cnt >= w) ? w - 1 : col_cnt;
        r     = (row_cnt >= h) ? h - 1 : row_cnt;
        frame_end = (c == w - 1) && (r == h - 1);
        if (prev_ok)
        begin
            src_r = r;
            src_c = c;
            if (flip_reg)
                src_r = h - 1 - r;
            else
                src_c = w - 1 - c;
            out_pix = pixel_store[(wr_bank ? 0 : BANK_WORDS) + src_r * MAX_WIDTH + src_c];
            if (blank != 0 && (c < blank || c + blank >= w))
                out_pix = '0;
            mirrored_q.push_back('{out_pix, frame_end});
        end
        pixel_store[(wr_bank ? BANK_WORDS : 0) + r * MAX_WIDTH + c] = pix;
        if (c + 1 < w)
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
        else
        begin
            col_cnt = 0;
            if (r + 1 < h)
                row_cnt = r + 1;
            else
            begin
                row_cnt = 0;
                wr_bank = ~wr_bank;
                prev_ok = 1'b1;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mirror_beat_t want;
        if (!rst_n)
        begin
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            flip_reg   = 1'b0;
            blank_reg  = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            wr_bank    = 1'b0;
            prev_ok    = 1'b0;
            mirrored_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (mirrored_q.size() == 0)
                begin
                    $error("out_pixel beat with nothing expected: got %h, out_frame_last %b",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = mirrored_q.pop_front();
                    if (m_axis_tdata !== want.pixel)
                    begin
                        $error("out_pixel: expected %h, got %h", want.pixel, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.frame_end)
                    begin
                        $error("out_frame_last: expected %b, got %b", want.frame_end, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                apply_reg_write(cfg_reg_t'(cfg_index), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                mirror_pixel(s_axis_tdata);
        end
        pending = mirrored_q.size();
    end

endmodule

/* tb/tb_frame_mirror_flip_with_blanking_unit.sv */
`timescale 1ns / 1ps

module tb_frame_mirror_flip_with_blanking_unit;
    import fmfb_pkg::*;

    localparam int PIXEL_TARGET = 1750;
    localparam int HOLD_PHASE   = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata  = '0;   // [31:0] in_pixel
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]     m_axis_tdata;         // [31:0] out_pixel
    logic                   m_axis_tlast;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int mismatches;
    int pending;
    int pixels_sent = 0;
    int phase_idx   = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int cycle_count = 0;

    logic [PIXEL_W-1:0] corner_px [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h89AB_CDEF,
        32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A
    };

    frame_mirror_flip_with_blanking_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_mirror_flip_checker flip_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** frame_mirror_flip_with_blanking_unit: FAILED **");
            $finish;
        end
    end

    // hold off the output once for a long stretch so the block backs up
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (phase_idx == HOLD_PHASE && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
        @(negedge clk);
    endtask

    // drop valid, wait for every expected beat, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    initial
    begin
        int unsigned w_cfg;
        int unsigned h_cfg;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned frame_px;
        int unsigned n;
        int unsigned pick;
        bit          new_geo;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_FLIP_MODE, 0);
        write_reg(REG_BLANK_COLS, 0);
        for (int i = 0; i < 8; i++)
            send_pixel(corner_px[i]);
        settle();
        write_reg(REG_FLIP_MODE, 1);
        for (int i = 0; i < 4; i++)
            send_pixel(corner_px[7 - i]);
        settle();
        write_reg(REG_BLANK_COLS, 1);
        for (int i = 0; i < 4; i++)
            send_pixel($urandom());
        settle();
        write_reg(REG_BLANK_COLS, 0);
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        for (int i = 0; i < 3; i++)
            send_pixel(corner_px[i]);
        settle();

        w_eff = 1;
        h_eff = 1;
        while (pixels_sent < PIXEL_TARGET)
        begin
            phase_idx++;
            case (phase_idx % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 77; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 77; end
                default: begin gap_pct = 12; stall_pct = 12; end
            endcase

            new_geo = (phase_idx <= 6) ||
                      (phase_idx != HOLD_PHASE && $urandom_range(0, 9) < 6);
            if (new_geo)
            begin
                case (phase_idx)
                    1: begin w_cfg = 64;  h_cfg = 1;   end
                    2: begin w_cfg = 127; h_cfg = 1;   end
                    3: begin w_cfg = 1;   h_cfg = 64;  end
                    4: begin w_cfg = 1;   h_cfg = 127; end
                    5: begin w_cfg = 0;   h_cfg = 3;   end
                    6: begin w_cfg = 5;   h_cfg = 0;   end
                    default:
                    begin
                        w_cfg = $urandom_range(1, 8);
                        h_cfg = $urandom_range(1, 6);
                    end
                endcase
                write_reg(REG_FRAME_WIDTH, w_cfg);
                write_reg(REG_FRAME_HEIGHT, h_cfg);
                w_eff = (w_cfg == 0) ? 1 : ((w_cfg > MAX_WIDTH) ? MAX_WIDTH : w_cfg);
                h_eff = (h_cfg == 0) ? 1 : ((h_cfg > MAX_HEIGHT) ? MAX_HEIGHT : h_cfg);
            end

            if (phase_idx <= 6)
                write_reg(REG_FLIP_MODE, phase_idx % 2);
            else if ($urandom_range(0, 9) < 7)
                write_reg(REG_FLIP_MODE, $urandom_range(0, 127));

            pick = $urandom_range(0, 9);
            if (phase_idx == 1)
                write_reg(REG_BLANK_COLS, 31);
            else if (phase_idx == 2)
                write_reg(REG_BLANK_COLS, 63);
            else if (phase_idx <= 4 || pick < 3)
                write_reg(REG_BLANK_COLS, 0);
            else if (pick < 7)
                write_reg(REG_BLANK_COLS, $urandom_range(1, w_eff));
            else if (pick == 7)
                write_reg(REG_BLANK_COLS, 32);
            else if (pick == 8)
                write_reg(REG_BLANK_COLS, $urandom_range(0, 127));

            frame_px = w_eff * h_eff;
            if (frame_px > 16)
                n = 2 * frame_px + $urandom_range(0, 8);
            else if (new_geo)
                n = frame_px * $urandom_range(2, 4) + $urandom_range(0, frame_px - 1);
            else
                n = $urandom_range(frame_px, 4 * frame_px);
            if (phase_idx == HOLD_PHASE && n < 80)
                n = 80;

            repeat (n) send_pixel($urandom());
            settle();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("** frame_mirror_flip_with_blanking_unit: PASSED **");
        else
            $display("** frame_mirror_flip_with_blanking_unit: FAILED **");
        $finish;
    end

endmodule
